// ===== src/urc_pkg.sv =====
// Shared types and constants for the ultrasonic range controller.
`timescale 1ns / 1ps

package urc_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;
  localparam int S_DATA_W   = 8;
  localparam int M_DATA_W   = 48;

  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_COUNT = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_US   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ECHO_US  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CYCLE_US     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_US_PER_INCH  = 3'd4;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_NO_ECHO = 2'd1;
  localparam logic [1:0] ERR_RANGE   = 2'd2;

  localparam logic [9:0]  INCHES_PER_FOOT = 10'd12;
  localparam logic [23:0] ACC_MAX         = 24'hFF_FFFF;
  localparam logic [17:0] CYC_MAX         = 18'h3_FFFF;

  localparam logic [5:0] DIV_STEPS_SHORT = 6'd16;
  localparam logic [5:0] DIV_STEPS_LONG  = 6'd32;
  localparam logic [3:0] MUL_STEPS       = 4'd8;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [9:0]  divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [9:0]  rem;
  } div_rsp_t;

endpackage

// ===== src/urc_serial_div.sv =====
// Restoring divider producing one quotient bit per cycle.
`timescale 1ns / 1ps

module urc_serial_div (
  input  logic               clk,
  input  logic               rst,
  input  urc_pkg::div_req_t  req,
  output urc_pkg::div_rsp_t  rsp
);
  import urc_pkg::*;

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [9:0]  rem;
  logic [9:0]  divisor;
  logic [31:0] quot;

  logic [10:0] trial;
  logic [10:0] diff;
  logic        ge;

  assign trial = {rem, quot[31]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quot    <= req.dividend;
        rem     <= '0;
        divisor <= req.divisor;
        cnt     <= req.steps;
        busy    <= 1'b1;
      end else if (busy) begin
        rem  <= ge ? diff[9:0] : trial[9:0];
        quot <= {quot[30:0], ge};
        cnt  <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quot: quot, rem: rem};

endmodule

// ===== src/ultrasonic_range_controller.sv =====
// Ultrasonic range controller: tick stream in, per-tick status stream out.
`timescale 1ns / 1ps

// Each input beat is one microsecond tick carrying the echo level and a start
// request; each yields exactly one result beat. A plain tick goes from
// acceptance to the push step, which loads the output register, and the input
// is ready again only once that push is done, so one tick is finished before
// the next is taken. The tick that ends a good measurement passes through
// three runs of a one-bit-per-cycle divider (16 steps for inches, 16 for feet
// and inches, 32 for the average), with an 8-step shift-add multiply between,
// before its push. A result waiting in the output register does not block
// acceptance of the next beat once it has been loaded; a stalled output holds
// the block in its push step and stalls input.
module ultrasonic_range_controller #(
  parameter int FRACTION_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [urc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [urc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // echo_level[0], start_req[1], zero[7:2]
  input  logic [urc_pkg::S_DATA_W-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // trigger_level[0], busy_res[1], sample_valid[2], sample_error[4:3],
  // sample_feet[17:5], sample_inch[21:18], average_q8[45:22], final_error[47:46]
  output logic [urc_pkg::M_DATA_W-1:0]   m_tdata,
  // series_done
  output logic                           m_tlast
);
  import urc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TRIG, PH_WAIT, PH_ECHO, PH_HOLD
  } phase_t;

  typedef enum logic [2:0] {
    E_IDLE, E_DIV_IN, E_DIV_FT, E_MUL, E_DIV_AVG, E_PUSH
  } eng_t;

  logic [7:0]  sample_count;
  logic [9:0]  trigger_us;
  logic [15:0] max_echo_us;
  logic [17:0] cycle_us;
  logic [9:0]  us_per_inch;

  phase_t      phase;
  logic [17:0] cycle_ticks;
  logic [15:0] phase_ticks;
  logic [7:0]  attempt_number;
  logic [23:0] average_acc;
  logic [1:0]  last_error;

  eng_t        eng;
  logic [15:0] inches;
  logic [31:0] prod;
  logic [7:0]  mult;
  logic [3:0]  mcnt;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        div_go;

  logic        res_trig;
  logic        res_busy;
  logic        res_sval;
  logic [1:0]  res_serr;
  logic [12:0] res_feet;
  logic [3:0]  res_inch;
  logic        res_done;
  logic [1:0]  res_ferr;

  // tick step
  logic        echo;
  logic        start;
  phase_t      ph_a;
  phase_t      phase_next;
  logic [17:0] ct_w;
  logic [16:0] pt_w;
  logic [16:0] limit_sum;
  logic [16:0] limit;
  logic [7:0]  an_next;
  logic        av_clr;
  logic [1:0]  le_next;
  logic        st_trig;
  logic        st_busy;
  logic        st_sval;
  logic [1:0]  st_serr;
  logic        st_done;
  logic [1:0]  st_ferr;
  logic        end_hit;
  logic [1:0]  end_err;
  logic        good_end;

  logic [7:0]  k;
  logic [7:0]  k_m1;
  logic [39:0] x_wide;
  logic [23:0] x_sat;
  logic [9:0]  divisor_in;

  assign echo       = s_tdata[0];
  assign start      = s_tdata[1];
  assign s_tready   = (eng == E_IDLE);
  assign limit_sum  = {7'b0, trigger_us} + {1'b0, max_echo_us};
  assign limit      = limit_sum[16] ? 17'h0_FFFF : limit_sum;
  assign k          = (attempt_number == 8'd0) ? 8'd1 : attempt_number;
  assign k_m1       = k - 8'd1;
  assign x_wide     = 40'(inches) << FRACTION_BITS;
  assign x_sat      = (|x_wide[39:24]) ? ACC_MAX : x_wide[23:0];
  assign divisor_in = (us_per_inch == 10'd0) ? 10'd1 : us_per_inch;
  assign div_go     = ((eng == E_IDLE) && s_tvalid && good_end) ||
                      ((eng == E_DIV_IN) && div_rsp.done) ||
                      ((eng == E_MUL) && (mcnt == 4'd0));

  always_comb begin
    ph_a       = phase;
    ct_w       = cycle_ticks;
    pt_w       = {1'b0, phase_ticks};
    an_next    = attempt_number;
    av_clr     = 1'b0;
    le_next    = last_error;
    st_trig    = 1'b0;
    st_busy    = 1'b0;
    st_sval    = 1'b0;
    st_serr    = ERR_NONE;
    st_done    = 1'b0;
    st_ferr    = ERR_NONE;
    end_hit    = 1'b0;
    end_err    = ERR_NONE;
    good_end   = 1'b0;

    if (phase == PH_IDLE) begin
      if (start) begin
        an_next = 8'd1;
        av_clr  = 1'b1;
        le_next = ERR_NONE;
        ph_a    = PH_TRIG;
        pt_w    = '0;
        ct_w    = '0;
      end
    end else if (phase == PH_HOLD && cycle_ticks >= cycle_us) begin
      if (attempt_number >= sample_count) begin
        ph_a    = PH_IDLE;
        st_done = 1'b1;
        st_ferr = last_error;
      end else begin
        an_next = attempt_number + 8'd1;
        ph_a    = PH_TRIG;
        pt_w    = '0;
        ct_w    = '0;
      end
    end

    phase_next = ph_a;
    unique case (ph_a)
      PH_TRIG: begin
        st_trig = 1'b1;
        pt_w    = pt_w + 17'd1;
        if (pt_w >= {7'b0, trigger_us}) begin
          phase_next = PH_WAIT;
          pt_w       = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase_next = PH_ECHO;
          pt_w       = 17'd1;
          if (pt_w >= {1'b0, max_echo_us}) begin
            end_hit = 1'b1;
            end_err = ERR_RANGE;
          end
        end else begin
          pt_w = pt_w + 17'd1;
          if (pt_w >= limit) begin
            end_hit = 1'b1;
            end_err = ERR_NO_ECHO;
          end
        end
      end
      PH_ECHO: begin
        if (!echo) begin
          end_hit  = 1'b1;
          end_err  = ERR_NONE;
          good_end = 1'b1;
        end else begin
          pt_w = pt_w + 17'd1;
          if (pt_w >= {1'b0, max_echo_us}) begin
            end_hit = 1'b1;
            end_err = ERR_RANGE;
          end
        end
      end
      PH_IDLE, PH_HOLD: begin
      end
      default: phase_next = PH_IDLE;
    endcase

    if (end_hit) begin
      st_sval    = 1'b1;
      st_serr    = end_err;
      le_next    = end_err;
      phase_next = PH_HOLD;
    end

    if (phase_next != PH_IDLE) begin
      st_busy = 1'b1;
      if (ct_w < CYC_MAX) begin
        ct_w = ct_w + 18'd1;
      end
    end
  end

  urc_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count   <= 8'd1;
      trigger_us     <= 10'd10;
      max_echo_us    <= 16'd23307;
      cycle_us       <= 18'd75000;
      us_per_inch    <= 10'd148;
      phase          <= PH_IDLE;
      cycle_ticks    <= '0;
      phase_ticks    <= '0;
      attempt_number <= '0;
      average_acc    <= '0;
      last_error     <= ERR_NONE;
      eng            <= E_IDLE;
      m_tvalid       <= 1'b0;
      div_req        <= '0;
      mcnt           <= '0;
    end else begin
      div_req.start <= div_go;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_SAMPLE_COUNT: sample_count <= cfg_wdata[7:0];
          REG_TRIGGER_US:   trigger_us   <= cfg_wdata[9:0];
          REG_MAX_ECHO_US:  max_echo_us  <= cfg_wdata[15:0];
          REG_CYCLE_US:     cycle_us     <= cfg_wdata[17:0];
          REG_US_PER_INCH:  us_per_inch  <= cfg_wdata[9:0];
          default: begin
          end
        endcase
      end

      if (m_tvalid && m_tready && (eng != E_PUSH)) begin
        m_tvalid <= 1'b0;
      end

      unique case (eng)
        E_IDLE: begin
          if (s_tvalid) begin
            phase          <= phase_next;
            cycle_ticks    <= ct_w;
            phase_ticks    <= pt_w[15:0];
            attempt_number <= an_next;
            last_error     <= le_next;
            if (av_clr) begin
              average_acc <= '0;
            end
            res_trig <= st_trig;
            res_busy <= st_busy;
            res_sval <= st_sval;
            res_serr <= st_serr;
            res_done <= st_done;
            res_ferr <= st_ferr;
            res_feet <= '0;
            res_inch <= '0;
            if (good_end) begin
              div_req.dividend <= {pt_w[15:0], 16'b0};
              div_req.divisor  <= divisor_in;
              div_req.steps    <= DIV_STEPS_SHORT;
              eng              <= E_DIV_IN;
            end else begin
              eng <= E_PUSH;
            end
          end
        end
        E_DIV_IN: begin
          if (div_rsp.done) begin
            inches           <= div_rsp.quot[15:0];
            div_req.dividend <= {div_rsp.quot[15:0], 16'b0};
            div_req.divisor  <= INCHES_PER_FOOT;
            div_req.steps    <= DIV_STEPS_SHORT;
            eng              <= E_DIV_FT;
          end
        end
        E_DIV_FT: begin
          if (div_rsp.done) begin
            res_feet <= div_rsp.quot[12:0];
            res_inch <= div_rsp.rem[3:0];
            prod     <= '0;
            mult     <= k_m1;
            mcnt     <= MUL_STEPS;
            eng      <= E_MUL;
          end
        end
        E_MUL: begin
          if (mcnt != 4'd0) begin
            prod <= {prod[30:0], 1'b0} + (mult[7] ? {8'b0, average_acc} : 32'd0);
            mult <= {mult[6:0], 1'b0};
            mcnt <= mcnt - 4'd1;
          end else begin
            div_req.dividend <= prod + {8'b0, x_sat};
            div_req.divisor  <= {2'b0, k};
            div_req.steps    <= DIV_STEPS_LONG;
            eng              <= E_DIV_AVG;
          end
        end
        E_DIV_AVG: begin
          if (div_rsp.done) begin
            average_acc <= div_rsp.quot[23:0];
            eng         <= E_PUSH;
          end
        end
        E_PUSH: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res_ferr, average_acc, res_inch, res_feet,
                         res_serr, res_sval, res_busy, res_trig};
            m_tlast  <= res_done;
            m_tvalid <= 1'b1;
            eng      <= E_IDLE;
          end
        end
        default: eng <= E_IDLE;
      endcase
    end
  end

endmodule

// ===== src/urc_checker.sv =====
// Port-level assertions for the ultrasonic range controller, with its bind.
`timescale 1ns / 1ps

module urc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [urc_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tlast
);
  import urc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_sample_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[4:3] == ERR_NONE && m_tdata[21:5] == 17'd0)
    else $error("sample fields set without sample_valid");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[1] && !m_tdata[2] && !m_tdata[0])
    else $error("series_done while still busy");

  a_final_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[47:46] == ERR_NONE)
    else $error("final_error set without series_done");

  a_codes: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[4:3] == ERR_NONE || m_tdata[4:3] == ERR_NO_ECHO ||
                  m_tdata[4:3] == ERR_RANGE) &&
                 (m_tdata[47:46] == ERR_NONE || m_tdata[47:46] == ERR_NO_ECHO ||
                  m_tdata[47:46] == ERR_RANGE))
    else $error("undefined error code");

endmodule

bind ultrasonic_range_controller urc_checker u_urc_checker (.*);
